[rtl/core/kmed_pkg.sv]
// kmed_pkg: constants, types and code tables for the key matrix event decoder
// no dependencies; used by every module of the block
`default_nettype none

package kmed_pkg;

    localparam int KEY_TOTAL    = 40;
    localparam int KEY_IDX_W    = $clog2(KEY_TOTAL);
    localparam int LANE_KEYS    = 8;
    localparam int LANE_COUNT   = KEY_TOTAL / LANE_KEYS;
    localparam int LANE_IDX_W   = $clog2(LANE_KEYS);
    localparam int CODE_W       = 7;

    localparam int CAPS_INDEX   = 34;
    localparam int SYMBOL_INDEX = 38;
    localparam int ZERO_INDEX   = 9;

    localparam logic [CODE_W-1:0] CODE_NONE      = 7'h00;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 7'h08;
    localparam logic [CODE_W-1:0] CASE_OFFSET    = 7'h20;
    localparam logic [CODE_W-1:0] LOWER_A        = 7'h61;
    localparam logic [CODE_W-1:0] LOWER_Z        = 7'h7A;

    localparam logic [CODE_W-1:0] PLAIN_CODES [KEY_TOTAL] = '{
        7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h74, 7'h72, 7'h65, 7'h77, 7'h71, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
        7'h67, 7'h66, 7'h64, 7'h73, 7'h61, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h0D,
        7'h76, 7'h63, 7'h78, 7'h7A, 7'h00, 7'h62, 7'h6E, 7'h6D, 7'h00, 7'h20
    };

    localparam logic [CODE_W-1:0] SYMBOL_CODES [KEY_TOTAL] = '{
        7'h25, 7'h24, 7'h23, 7'h40, 7'h21, 7'h26, 7'h27, 7'h28, 7'h29, 7'h5F,
        7'h3E, 7'h3C, 7'h00, 7'h00, 7'h00, 7'h5B, 7'h5D, 7'h00, 7'h3B, 7'h22,
        7'h7D, 7'h7B, 7'h5C, 7'h7C, 7'h7E, 7'h5E, 7'h2D, 7'h2B, 7'h3D, 7'h0D,
        7'h2F, 7'h3F, 7'h00, 7'h3A, 7'h00, 7'h2A, 7'h2C, 7'h2E, 7'h00, 7'h20
    };

    // what one lane found among its keys
    typedef struct packed {
        logic                  any;
        logic                  multi;
        logic [LANE_IDX_W-1:0] idx;
    } t_lane_res;

    function automatic logic [CODE_W-1:0] code_for(
        input logic [KEY_IDX_W-1:0] idx,
        input logic                 caps,
        input logic                 sym
    );
        logic [CODE_W-1:0] v;
        v = CODE_NONE;
        if (idx < KEY_IDX_W'(KEY_TOTAL)) begin
            v = sym ? SYMBOL_CODES[idx] : PLAIN_CODES[idx];
        end
        if (idx >= KEY_IDX_W'(KEY_TOTAL)) begin
            code_for = CODE_NONE;
        end else if (caps && sym) begin
            code_for = CODE_NONE;
        end else if (caps && idx == KEY_IDX_W'(ZERO_INDEX)) begin
            code_for = CODE_BACKSPACE;
        end else if (caps) begin
            code_for = (v >= LOWER_A && v <= LOWER_Z) ? v - CASE_OFFSET : CODE_NONE;
        end else begin
            code_for = v;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/kmed_key_if.sv]
// kmed_key_if: valid/ready channel carrying one matrix scan item
// depends on kmed_pkg for the matrix width
`default_nettype none

interface kmed_key_if;
    logic                           valid;
    logic                           ready;
    logic [kmed_pkg::KEY_TOTAL-1:0] key_matrix;

    modport source (output valid, output key_matrix, input ready);
    modport sink   (input valid, input key_matrix, output ready);
endinterface

`default_nettype wire

[rtl/core/kmed_code_if.sv]
// kmed_code_if: valid/ready channel carrying one decoded character item
// depends on kmed_pkg for the code width
`default_nettype none

interface kmed_code_if;
    logic                        valid;
    logic                        ready;
    logic [kmed_pkg::CODE_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

[rtl/core/key_matrix_event_decoder_top.sv]
// key_matrix_event_decoder_top: lane scan, then merge and output register
// throughput one scan item per cycle while the output channel is not stalled
// lane stage stalls only when full while a result waits, else a scan is taken
// synchronous active-low reset clears the valid flags and the press latch
// depends on kmed_pkg, kmed_key_if, kmed_code_if, kmed_lane, kmed_merge
`default_nettype none

module key_matrix_event_decoder_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    kmed_key_if.sink     i_key_ch,
    kmed_code_if.source  o_code_ch
);
    import kmed_pkg::*;

    t_lane_res           lane_res   [LANE_COUNT];
    t_lane_res           r_s1_lane  [LANE_COUNT];
    logic                r_s1_valid;
    logic                r_s1_caps;
    logic                r_s1_sym;
    logic                r_latched;
    logic                n_latched;
    logic                r_out_valid;
    logic [CODE_W-1:0]   r_char_code;
    logic [CODE_W-1:0]   char_code;
    logic                en_s1;
    logic                en_out;

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        kmed_lane #(
            .LANE_BASE(g * LANE_KEYS)
        ) u_lane (
            .i_keys(i_key_ch.key_matrix[g*LANE_KEYS +: LANE_KEYS]),
            .o_res (lane_res[g])
        );
    end

    kmed_merge u_merge (
        .i_lane_res    (r_s1_lane),
        .i_caps        (r_s1_caps),
        .i_sym         (r_s1_sym),
        .i_latched     (r_latched),
        .o_char_code   (char_code),
        .o_latched_next(n_latched)
    );

    assign en_out         = !r_out_valid || o_code_ch.ready;
    assign en_s1          = !r_s1_valid || en_out;
    assign i_key_ch.ready = en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= i_key_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1 && i_key_ch.valid) begin
            r_s1_lane <= lane_res;
            r_s1_caps <= i_key_ch.key_matrix[CAPS_INDEX];
            r_s1_sym  <= i_key_ch.key_matrix[SYMBOL_INDEX];
        end
    end

    // latch moves only when a scan leaves the lane stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_latched   <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_latched <= n_latched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s1_valid) begin
            r_char_code <= char_code;
        end
    end

    assign o_code_ch.valid     = r_out_valid;
    assign o_code_ch.char_code = r_char_code;

endmodule

`default_nettype wire

[rtl/core/kmed_lane.sv]
// kmed_lane: scans one slice of the key matrix for pressed keys
// depends on kmed_pkg; the shift keys are masked out by their global index
`default_nettype none

module kmed_lane #(
    parameter int LANE_BASE = 0
) (
    input  wire logic [kmed_pkg::LANE_KEYS-1:0] i_keys,
    output kmed_pkg::t_lane_res                 o_res
);
    import kmed_pkg::*;

    logic [LANE_KEYS-1:0] keys_masked;
    logic                 seen;
    logic                 multi;
    logic [LANE_IDX_W-1:0] first;

    always_comb begin
        for (int j = 0; j < LANE_KEYS; j++) begin
            keys_masked[j] = i_keys[j] && (LANE_BASE + j != CAPS_INDEX)
                                       && (LANE_BASE + j != SYMBOL_INDEX);
        end
    end

    // lowest pressed key wins, a second one marks the lane as multi
    always_comb begin
        seen  = 1'b0;
        multi = 1'b0;
        first = '0;
        for (int j = 0; j < LANE_KEYS; j++) begin
            if (keys_masked[j]) begin
                if (seen) begin
                    multi = 1'b1;
                end else begin
                    first = LANE_IDX_W'(j);
                end
                seen = 1'b1;
            end
        end
    end

    assign o_res.any   = seen;
    assign o_res.multi = multi;
    assign o_res.idx   = first;

endmodule

`default_nettype wire

[rtl/core/kmed_merge.sv]
// kmed_merge: combines the lane results, looks up the code, updates the latch
// depends on kmed_pkg for the lane types and code tables
`default_nettype none

module kmed_merge (
    input  wire kmed_pkg::t_lane_res          i_lane_res [kmed_pkg::LANE_COUNT],
    input  wire logic                         i_caps,
    input  wire logic                         i_sym,
    input  wire logic                         i_latched,
    output logic [kmed_pkg::CODE_W-1:0]       o_char_code,
    output logic                              o_latched_next
);
    import kmed_pkg::*;

    logic                 any_key;
    logic                 many_keys;
    logic [KEY_IDX_W-1:0] found;

    always_comb begin
        any_key   = 1'b0;
        many_keys = 1'b0;
        found     = '0;
        for (int l = 0; l < LANE_COUNT; l++) begin
            if (i_lane_res[l].any) begin
                if (any_key || i_lane_res[l].multi) begin
                    many_keys = 1'b1;
                end
                if (!any_key) begin
                    found = KEY_IDX_W'(l * LANE_KEYS) + KEY_IDX_W'(i_lane_res[l].idx);
                end
                any_key = 1'b1;
            end
        end
    end

    always_comb begin
        o_char_code    = CODE_NONE;
        o_latched_next = i_latched;
        if (!any_key) begin
            o_latched_next = 1'b0;
        end else if (!i_latched) begin
            o_latched_next = 1'b1;
            if (!many_keys) begin
                o_char_code = code_for(found, i_caps, i_sym);
            end
        end
    end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench for key_matrix_event_decoder_top: scans go in, one character code per scan comes out
// decode is predicted in-house with its own latch and code tables
// needs kmed_pkg and both channel interfaces

module testbench;

    localparam int KEYS        = kmed_pkg::KEY_TOTAL;
    localparam int CODE_BITS   = kmed_pkg::CODE_W;
    localparam int CAPS_KEY    = 34;
    localparam int SYMBOL_KEY  = 38;
    localparam int ZERO_KEY    = 9;
    localparam int SPACE_KEY   = 39;
    localparam int ENTER_KEY   = 29;
    localparam int A_KEY       = 24;
    localparam int E_KEY       = 12;
    localparam logic [CODE_BITS-1:0] NO_EVENT  = 7'h00;
    localparam logic [CODE_BITS-1:0] BACKSPACE = 7'h08;
    localparam logic [CODE_BITS-1:0] UPPER_GAP = 7'h20;
    localparam logic [CODE_BITS-1:0] SMALL_A   = 7'h61;
    localparam logic [CODE_BITS-1:0] SMALL_Z   = 7'h7A;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_SLACK = 8;

    // key order follows the matrix half-rows
    localparam logic [CODE_BITS-1:0] PLAIN_CHARS [KEYS] = '{
        7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h74, 7'h72, 7'h65, 7'h77, 7'h71, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
        7'h67, 7'h66, 7'h64, 7'h73, 7'h61, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h0D,
        7'h76, 7'h63, 7'h78, 7'h7A, 7'h00, 7'h62, 7'h6E, 7'h6D, 7'h00, 7'h20
    };
    localparam logic [CODE_BITS-1:0] SYMBOL_CHARS [KEYS] = '{
        7'h25, 7'h24, 7'h23, 7'h40, 7'h21, 7'h26, 7'h27, 7'h28, 7'h29, 7'h5F,
        7'h3E, 7'h3C, 7'h00, 7'h00, 7'h00, 7'h5B, 7'h5D, 7'h00, 7'h3B, 7'h22,
        7'h7D, 7'h7B, 7'h5C, 7'h7C, 7'h7E, 7'h5E, 7'h2D, 7'h2B, 7'h3D, 7'h0D,
        7'h2F, 7'h3F, 7'h00, 7'h3A, 7'h00, 7'h2A, 7'h2C, 7'h2E, 7'h00, 7'h20
    };

    logic clk;
    logic rst_n;

    kmed_key_if  key_ch ();
    kmed_code_if code_ch ();

    key_matrix_event_decoder_top dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_key_ch  (key_ch),
        .o_code_ch (code_ch)
    );

    logic                 key_latched;
    logic [CODE_BITS-1:0] expected_chars [$];
    logic [CODE_BITS-1:0] oldest_char;
    int                   mismatch_count;
    int                   scans_sent;
    int                   quiet_cycles;
    int                   src_idle_pct;
    int                   sink_idle_pct;
    logic                 hold_req;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [KEYS-1:0] key_bit(input int idx);
        logic [KEYS-1:0] v;
        v = '0;
        v[idx] = 1'b1;
        return v;
    endfunction

    // updates the press latch as the block would and gives the code for this scan
    function automatic logic [CODE_BITS-1:0] decode_scan(input logic [KEYS-1:0] scan);
        logic                 caps;
        logic                 sym;
        int                   hits;
        int                   first;
        logic [CODE_BITS-1:0] entry;
        logic [CODE_BITS-1:0] ch;
        caps  = scan[CAPS_KEY];
        sym   = scan[SYMBOL_KEY];
        hits  = 0;
        first = 0;
        ch    = NO_EVENT;
        for (int i = 0; i < KEYS; i++) begin
            if (i != CAPS_KEY && i != SYMBOL_KEY && scan[i]) begin
                if (hits == 0) first = i;
                hits++;
            end
        end
        if (hits == 0) begin
            key_latched = 1'b0;
        end else if (!key_latched) begin
            key_latched = 1'b1;
            if (hits == 1) begin
                entry = sym ? SYMBOL_CHARS[first] : PLAIN_CHARS[first];
                if (caps && sym) begin
                    ch = NO_EVENT;
                end else if (caps && first == ZERO_KEY) begin
                    ch = BACKSPACE;
                end else if (caps) begin
                    ch = (entry >= SMALL_A && entry <= SMALL_Z) ? entry - UPPER_GAP : NO_EVENT;
                end else begin
                    ch = entry;
                end
            end
        end
        return ch;
    endfunction

    function automatic int pick_key();
        int k;
        do k = $urandom_range(KEYS - 1, 0);
        while (k == CAPS_KEY || k == SYMBOL_KEY);
        return k;
    endfunction

    function automatic logic [KEYS-1:0] random_shifts();
        logic [KEYS-1:0] v;
        v = '0;
        v[CAPS_KEY]   = ($urandom_range(2, 0) == 0);
        v[SYMBOL_KEY] = ($urandom_range(2, 0) == 0);
        return v;
    endfunction

    // called and left at a falling edge; valid stays up for the next item
    task automatic send_scan(input logic [KEYS-1:0] scan);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            key_ch.valid <= 1'b0;
            @(negedge clk);
        end
        key_ch.valid      <= 1'b1;
        key_ch.key_matrix <= scan;
        do @(posedge clk);
        while (!key_ch.ready);
        expected_chars.push_back(decode_scan(scan));
        scans_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        key_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // release, press, maybe hold or roll onto another key, maybe release
    task automatic send_keystroke();
        logic [KEYS-1:0] held;
        int              extra;
        send_scan(($urandom_range(1, 0) == 0) ? '0 : random_shifts());
        held = key_bit(pick_key()) | random_shifts();
        send_scan(held);
        extra = $urandom_range(2, 0);
        repeat (extra) begin
            if ($urandom_range(1, 0) == 0) held = held | key_bit(pick_key());
            send_scan(held);
        end
        if ($urandom_range(3, 0) != 0) send_scan(random_shifts());
    endtask

    task automatic test_directed();
        send_scan('0);
        send_scan('1);
        send_scan('0);
        send_scan(key_bit(0));
        send_scan(key_bit(1));
        send_scan('0);
        send_scan(key_bit(CAPS_KEY) | key_bit(ZERO_KEY));
        send_scan(key_bit(CAPS_KEY));
        send_scan(key_bit(A_KEY));
        send_scan(key_bit(CAPS_KEY) | key_bit(SYMBOL_KEY));
        send_scan(key_bit(CAPS_KEY) | key_bit(A_KEY));
        send_scan('0);
        send_scan(key_bit(SYMBOL_KEY) | key_bit(0));
        send_scan('0);
        send_scan(key_bit(CAPS_KEY) | key_bit(SYMBOL_KEY) | key_bit(A_KEY));
        send_scan('0);
        send_scan(key_bit(CAPS_KEY) | key_bit(0));
        send_scan('0);
        send_scan(key_bit(SYMBOL_KEY) | key_bit(E_KEY));
        send_scan(key_bit(SYMBOL_KEY));
        send_scan(key_bit(SPACE_KEY));
        send_scan('0);
        send_scan(key_bit(ENTER_KEY));
        send_scan('0);
        send_scan(key_bit(0) | key_bit(SPACE_KEY));
        send_scan('0);
    endtask

    task automatic test_random_typing(input int count);
        int target;
        target = scans_sent + count;
        while (scans_sent < target) begin
            if ($urandom_range(99, 0) < 80) begin
                send_keystroke();
            end else if ($urandom_range(1, 0) == 0) begin
                send_scan(KEYS'({$urandom, $urandom}));
            end else begin
                send_scan(key_bit(pick_key()) | key_bit(pick_key()) | random_shifts());
            end
        end
    endtask

    // output held off long enough for the block to back up onto its input
    task automatic test_output_stall();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (12) send_keystroke();
        wait_for_drain();
    endtask

    initial begin : sink_ready
        code_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                code_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            code_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && code_ch.valid && code_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $error("char_code %0h arrived with nothing expected", code_ch.char_code);
                mismatch_count++;
            end else begin
                oldest_char = expected_chars.pop_front();
                if (code_ch.char_code !== oldest_char) begin
                    $error("char_code: expected %0h, actual %0h", oldest_char, code_ch.char_code);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((key_ch.valid && key_ch.ready) || (code_ch.valid && code_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n             = 1'b0;
        key_ch.valid      = 1'b0;
        key_ch.key_matrix = '0;
        key_latched       = 1'b0;
        mismatch_count    = 0;
        scans_sent        = 0;
        quiet_cycles      = 0;
        hold_req          = 1'b0;
        src_idle_pct      = 0;
        sink_idle_pct     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        wait_for_drain();

        src_idle_pct  = 8;
        sink_idle_pct = 61;
        test_random_typing(480);

        test_output_stall();

        src_idle_pct  = 61;
        sink_idle_pct = 8;
        test_random_typing(480);
        wait_for_drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_typing(480);

        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
